@@ hdl/thwm_pkg.sv @@
// ----------------------------------------------------------------------------
// thwm_pkg
// Shared widths and types for the triangle projective warp map.
// ----------------------------------------------------------------------------
package thwm_pkg;

	localparam int COEF_W    = 32;              // Q16.16 coefficient
	localparam int TID_W     = 9;
	localparam int CIDX_W    = 4;
	localparam int PIX_W     = 12;
	localparam int NCOEF     = 9;
	localparam int OUT_FRAC  = 12;
	localparam int OUT_W     = 32;
	localparam int PROD_W    = COEF_W + PIX_W + 1;   // coef * unsigned pixel
	localparam int SUM_W     = PROD_W + 2;           // sum of three products
	localparam int NUM_W     = SUM_W + OUT_FRAC;     // |n| << 12
	localparam int Q_BITS    = OUT_W + 1;            // quotient bits developed
	localparam int HI_W      = NUM_W - Q_BITS;       // numerator bits above them
	localparam int IN_DATA_W = 72;
	localparam int OUT_DATA_W = 2 * OUT_W;

	// row-major coefficient positions
	localparam int C_H00 = 0;
	localparam int C_H01 = 1;
	localparam int C_H02 = 2;
	localparam int C_H10 = 3;
	localparam int C_H11 = 4;
	localparam int C_H12 = 5;
	localparam int C_H20 = 6;
	localparam int C_H21 = 7;
	localparam int C_H22 = 8;

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	typedef logic [NCOEF-1:0][COEF_W-1:0] coef_row_t;

	// per-pixel side information carried along the pipeline
	typedef struct packed {
		logic             ident;
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
	} pix_meta_t;

	typedef struct packed {
		pix_meta_t pix;
		logic      neg_x;
		logic      neg_y;
		logic      ovf_x;
		logic      ovf_y;
	} div_meta_t;

endpackage

@@ hdl/triangle_homography_warp_map_top.sv @@
// ----------------------------------------------------------------------------
// triangle_homography_warp_map_top
// Per-pixel source coordinate map for piecewise projective warping.
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser = mode (0 loads one matrix coefficient, 1 maps
// one pixel). Coefficient loads produce no output transfer; each pixel gives
// one output transfer on m_axis with the Q20.12 source position.
// One item is taken per clock unless the output stalls. A pixel's result
// passes through one table read, three stages of multiply, sum and
// magnitude, one divider setup stage, 33 one-bit divider stages and the
// output register; throughput is one item per cycle unless the output stalls.
// A coefficient load takes effect for any pixel accepted after it.
// The whole pipeline advances together: when the output holds a result that
// the receiver does not take, s_axis_tready drops and every stage holds.
// Reset clears the valid bits only; the matrix table is undefined until
// written and a pixel naming an unwritten triangle returns arbitrary values.
// Triangle 0 or a number above MAX_TRIANGLES maps the pixel to itself.
// ----------------------------------------------------------------------------
module triangle_homography_warp_map_top #(
	parameter int MAX_TRIANGLES = 256,
	parameter int COORD_BITS    = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [8:0] triangle_id, [12:9] coef_index, [44:13] coef_value,
	// [56:45] pixel_x, [68:57] pixel_y, [71:69] zero
	input  logic [71:0] s_axis_tdata,
	input  logic        s_axis_tuser,   // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] source_x, [63:32] source_y
	output logic [1:0]  m_axis_tuser    // [0] in_triangle, [1] saturated
);

	localparam int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
	localparam int PW = thwm_pkg::PIX_W;
	localparam int OW = thwm_pkg::OUT_W;
	localparam int QB = thwm_pkg::Q_BITS;
	localparam logic [PW-1:0] CMASK =
		(COORD_BITS >= PW) ? {PW{1'b1}} : PW'((1 << COORD_BITS) - 1);
	localparam logic [QB-1:0] POS_MAX = QB'({1'b0, {(OW-1){1'b1}}});
	localparam logic [QB-1:0] NEG_MAX = QB'({1'b1, {(OW-1){1'b0}}});

	logic                        ce, accept;
	logic                        mode;
	logic [thwm_pkg::TID_W-1:0]  tid;
	logic [thwm_pkg::CIDX_W-1:0] cidx;
	logic [thwm_pkg::COEF_W-1:0] cval;
	logic [31:0]                 tid32, idx32;
	logic                        tid_ok;
	logic [AW-1:0]               row;

	logic                        valid_s1;
	thwm_pkg::pix_meta_t         meta_s1, meta_s4;
	thwm_pkg::coef_row_t         coef_s1;
	logic                        valid_s4, neg_x_s4, neg_y_s4;
	logic [thwm_pkg::NUM_W-1:0]  num_x_s4, num_y_s4;
	logic [thwm_pkg::SUM_W-1:0]  den_s4;

	logic                        dvalid;
	thwm_pkg::div_meta_t         dmeta;
	logic [QB-1:0]               qx, qy;
	logic [OW-1:0]               sx_c, sy_c;
	logic                        satx_c, saty_c;

	assign mode  = s_axis_tuser;
	assign tid   = s_axis_tdata[8:0];
	assign cidx  = s_axis_tdata[12:9];
	assign cval  = s_axis_tdata[44:13];
	assign tid32 = 32'(tid);
	assign idx32 = tid32 - 32'd1;
	assign row   = idx32[AW-1:0];
	assign tid_ok = (tid32 >= 32'd1) && (tid32 <= 32'(MAX_TRIANGLES));

	assign ce            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;
	assign accept        = s_axis_tvalid && s_axis_tready;

	thwm_coef_mem #(.AW(AW), .DEPTH(MAX_TRIANGLES)) u_mem (
		.clk        (clk),
		.ce         (ce),
		.wr_en      (accept && (mode == thwm_pkg::MODE_WRITE) && tid_ok &&
		             (cidx < thwm_pkg::CIDX_W'(thwm_pkg::NCOEF))),
		.wr_bank    (cidx),
		.wr_addr    (row),
		.wr_data    (cval),
		.rd_addr    (row),
		.rd_data_s1 (coef_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= accept && (mode == thwm_pkg::MODE_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			meta_s1.ident <= !tid_ok;
			meta_s1.x     <= s_axis_tdata[56:45] & CMASK;
			meta_s1.y     <= s_axis_tdata[68:57] & CMASK;
		end
	end

	thwm_proj u_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.valid_s1 (valid_s1),
		.meta_s1  (meta_s1),
		.coef_s1  (coef_s1),
		.valid_s4 (valid_s4),
		.meta_s4  (meta_s4),
		.num_x_s4 (num_x_s4),
		.num_y_s4 (num_y_s4),
		.den_s4   (den_s4),
		.neg_x_s4 (neg_x_s4),
		.neg_y_s4 (neg_y_s4)
	);

	thwm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.valid_in  (valid_s4),
		.meta_in   (meta_s4),
		.num_x     (num_x_s4),
		.num_y     (num_y_s4),
		.den       (den_s4),
		.neg_x     (neg_x_s4),
		.neg_y     (neg_y_s4),
		.valid_out (dvalid),
		.meta_out  (dmeta),
		.quo_x     (qx),
		.quo_y     (qy)
	);

	// sign and saturation
	always_comb begin
		logic [QB-1:0] nqx, nqy;
		nqx = -qx;
		nqy = -qy;
		satx_c = 1'b0;
		saty_c = 1'b0;
		if (dmeta.ovf_x || (dmeta.neg_x ? (qx > NEG_MAX) : (qx > POS_MAX))) begin
			satx_c = 1'b1;
			sx_c   = dmeta.neg_x ? NEG_MAX[OW-1:0] : POS_MAX[OW-1:0];
		end else begin
			sx_c   = dmeta.neg_x ? nqx[OW-1:0] : qx[OW-1:0];
		end
		if (dmeta.ovf_y || (dmeta.neg_y ? (qy > NEG_MAX) : (qy > POS_MAX))) begin
			saty_c = 1'b1;
			sy_c   = dmeta.neg_y ? NEG_MAX[OW-1:0] : POS_MAX[OW-1:0];
		end else begin
			sy_c   = dmeta.neg_y ? nqy[OW-1:0] : qy[OW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (ce) begin
			m_axis_tvalid <= dvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			if (dmeta.pix.ident) begin
				m_axis_tdata <= {OW'({dmeta.pix.y, {thwm_pkg::OUT_FRAC{1'b0}}}),
				                 OW'({dmeta.pix.x, {thwm_pkg::OUT_FRAC{1'b0}}})};
				m_axis_tuser <= 2'b00;
			end else begin
				m_axis_tdata <= {sy_c, sx_c};
				m_axis_tuser <= {satx_c || saty_c, 1'b1};
			end
		end
	end

`ifndef SYNTH
	a_ident_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> !m_axis_tuser[1])
		else $error("identity result flagged saturated");

	a_ident_integral: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |->
		m_axis_tdata[11:0] == '0 && m_axis_tdata[43:32] == '0)
		else $error("identity result has fraction bits");

	a_sat_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
		m_axis_tdata[30:0] == '1 || m_axis_tdata[30:0] == '0 ||
		m_axis_tdata[62:32] == '1 || m_axis_tdata[62:32] == '0)
		else $error("saturated result not at a rail");
`endif

endmodule

@@ hdl/thwm_coef_mem.sv @@
// ----------------------------------------------------------------------------
// thwm_coef_mem
// Matrix table: one bank per coefficient, one row per triangle.
// ----------------------------------------------------------------------------
module thwm_coef_mem #(
	parameter int AW    = 8,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  ce,
	input  logic                                  wr_en,
	input  logic [thwm_pkg::CIDX_W-1:0]           wr_bank,
	input  logic [AW-1:0]                         wr_addr,
	input  logic [thwm_pkg::COEF_W-1:0]           wr_data,
	input  logic [AW-1:0]                         rd_addr,
	output thwm_pkg::coef_row_t                   rd_data_s1
);

	for (genvar b = 0; b < thwm_pkg::NCOEF; b++) begin : g_bank
		logic [thwm_pkg::COEF_W-1:0] mem [DEPTH];

		always_ff @(posedge clk) begin
			if (wr_en && (wr_bank == thwm_pkg::CIDX_W'(b))) begin
				mem[wr_addr] <= wr_data;
			end
			if (ce) begin
				rd_data_s1[b] <= mem[rd_addr];
			end
		end
	end

endmodule

@@ hdl/thwm_proj.sv @@
// ----------------------------------------------------------------------------
// thwm_proj
// Projective row sums: products, sums, then sign/magnitude for the divider.
// ----------------------------------------------------------------------------
module thwm_proj (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             ce,
	input  logic                             valid_s1,
	input  thwm_pkg::pix_meta_t              meta_s1,
	input  thwm_pkg::coef_row_t              coef_s1,
	output logic                             valid_s4,
	output thwm_pkg::pix_meta_t              meta_s4,
	output logic [thwm_pkg::NUM_W-1:0]       num_x_s4,
	output logic [thwm_pkg::NUM_W-1:0]       num_y_s4,
	output logic [thwm_pkg::SUM_W-1:0]       den_s4,
	output logic                             neg_x_s4,
	output logic                             neg_y_s4
);

	localparam int PW = thwm_pkg::PROD_W;
	localparam int SW = thwm_pkg::SUM_W;

	logic signed [PW-1:0]     prod_s2 [thwm_pkg::NCOEF];
	logic                     valid_s2, valid_s3;
	thwm_pkg::pix_meta_t      meta_s2, meta_s3;
	logic signed [SW-1:0]     nx_s3, ny_s3, z_s3;
	logic signed [PW-1:0]     xe, ye;
	logic signed [SW-1:0]     nx_c, ny_c, z_c;
	logic [SW-1:0]            mx_c, my_c, mz_c;

	// pixel coordinates are unsigned; widen to the product width
	assign xe = $signed(PW'(meta_s1.x));
	assign ye = $signed(PW'(meta_s1.y));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (ce) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int r = 0; r < 3; r++) begin
				prod_s2[3*r]   <= PW'($signed(coef_s1[3*r])) * xe;
				prod_s2[3*r+1] <= PW'($signed(coef_s1[3*r+1])) * ye;
				prod_s2[3*r+2] <= PW'($signed(coef_s1[3*r+2]));
			end
			meta_s2 <= meta_s1;
		end
	end

	assign nx_c = SW'(prod_s2[thwm_pkg::C_H00]) + SW'(prod_s2[thwm_pkg::C_H01])
	            + SW'(prod_s2[thwm_pkg::C_H02]);
	assign ny_c = SW'(prod_s2[thwm_pkg::C_H10]) + SW'(prod_s2[thwm_pkg::C_H11])
	            + SW'(prod_s2[thwm_pkg::C_H12]);
	assign z_c  = SW'(prod_s2[thwm_pkg::C_H20]) + SW'(prod_s2[thwm_pkg::C_H21])
	            + SW'(prod_s2[thwm_pkg::C_H22]);

	always_ff @(posedge clk) begin
		if (ce) begin
			nx_s3   <= nx_c;
			ny_s3   <= ny_c;
			// zero denominator becomes one LSB
			z_s3    <= (z_c == '0) ? SW'(1) : z_c;
			meta_s3 <= meta_s2;
		end
	end

	assign mx_c = nx_s3[SW-1] ? -nx_s3 : nx_s3;
	assign my_c = ny_s3[SW-1] ? -ny_s3 : ny_s3;
	assign mz_c = z_s3[SW-1]  ? -z_s3  : z_s3;

	always_ff @(posedge clk) begin
		if (ce) begin
			num_x_s4 <= {mx_c, {thwm_pkg::OUT_FRAC{1'b0}}};
			num_y_s4 <= {my_c, {thwm_pkg::OUT_FRAC{1'b0}}};
			den_s4   <= mz_c;
			neg_x_s4 <= nx_s3[SW-1] ^ z_s3[SW-1];
			neg_y_s4 <= ny_s3[SW-1] ^ z_s3[SW-1];
			meta_s4  <= meta_s3;
		end
	end

endmodule

@@ hdl/thwm_div.sv @@
// ----------------------------------------------------------------------------
// thwm_div
// Pipelined restoring divider, two numerators over one denominator,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module thwm_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             ce,
	input  logic                             valid_in,
	input  thwm_pkg::pix_meta_t              meta_in,
	input  logic [thwm_pkg::NUM_W-1:0]       num_x,
	input  logic [thwm_pkg::NUM_W-1:0]       num_y,
	input  logic [thwm_pkg::SUM_W-1:0]       den,
	input  logic                             neg_x,
	input  logic                             neg_y,
	output logic                             valid_out,
	output thwm_pkg::div_meta_t              meta_out,
	output logic [thwm_pkg::Q_BITS-1:0]      quo_x,
	output logic [thwm_pkg::Q_BITS-1:0]      quo_y
);

	localparam int QB = thwm_pkg::Q_BITS;
	localparam int SW = thwm_pkg::SUM_W;
	localparam int HW = thwm_pkg::HI_W;

	logic                   vld_s  [QB+1];
	thwm_pkg::div_meta_t    meta_s [QB+1];
	logic [SW-1:0]          den_s  [QB+1];
	logic [SW-1:0]          rx_s   [QB+1];
	logic [SW-1:0]          ry_s   [QB+1];
	logic [QB-1:0]          lx_s   [QB+1];
	logic [QB-1:0]          ly_s   [QB+1];
	logic [QB-1:0]          qx_s   [QB+1];
	logic [QB-1:0]          qy_s   [QB+1];

	// entry stage: quotient overflow check and partial remainder setup
	always_ff @(posedge clk) begin
		if (ce) begin
			meta_s[0].pix   <= meta_in;
			meta_s[0].neg_x <= neg_x;
			meta_s[0].neg_y <= neg_y;
			meta_s[0].ovf_x <= SW'(num_x[thwm_pkg::NUM_W-1 -: HW]) >= den;
			meta_s[0].ovf_y <= SW'(num_y[thwm_pkg::NUM_W-1 -: HW]) >= den;
			den_s[0]        <= den;
			rx_s[0]         <= SW'(num_x[thwm_pkg::NUM_W-1 -: HW]);
			ry_s[0]         <= SW'(num_y[thwm_pkg::NUM_W-1 -: HW]);
			lx_s[0]         <= num_x[QB-1:0];
			ly_s[0]         <= num_y[QB-1:0];
			qx_s[0]         <= '0;
			qy_s[0]         <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= QB; j++) vld_s[j] <= 1'b0;
		end else if (ce) begin
			vld_s[0] <= valid_in;
			for (int j = 0; j < QB; j++) vld_s[j+1] <= vld_s[j];
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_stage
		logic [SW:0] tx, ty, dx, dy;

		assign tx = {rx_s[j], lx_s[j][QB-1]};
		assign ty = {ry_s[j], ly_s[j][QB-1]};
		assign dx = tx - {1'b0, den_s[j]};
		assign dy = ty - {1'b0, den_s[j]};

		always_ff @(posedge clk) begin
			if (ce) begin
				// remainder stays below den, so it fits SW bits
				rx_s[j+1]   <= dx[SW] ? tx[SW-1:0] : dx[SW-1:0];
				ry_s[j+1]   <= dy[SW] ? ty[SW-1:0] : dy[SW-1:0];
				qx_s[j+1]   <= {qx_s[j][QB-2:0], ~dx[SW]};
				qy_s[j+1]   <= {qy_s[j][QB-2:0], ~dy[SW]};
				lx_s[j+1]   <= {lx_s[j][QB-2:0], 1'b0};
				ly_s[j+1]   <= {ly_s[j][QB-2:0], 1'b0};
				den_s[j+1]  <= den_s[j];
				meta_s[j+1] <= meta_s[j];
			end
		end
	end

	assign valid_out = vld_s[QB];
	assign meta_out  = meta_s[QB];
	assign quo_x     = qx_s[QB];
	assign quo_y     = qy_s[QB];

endmodule
